/* rtl/rusanov_euler_flux_2d_unit_macros.svh */
// Assertion macros for the Rusanov flux unit.
`ifndef RUSANOV_EULER_FLUX_2D_UNIT_MACROS_SVH
`define RUSANOV_EULER_FLUX_2D_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define RUSFLX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rusflx same-cycle check failed");
`define RUSFLX_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rusflx next-cycle check failed");
`else
`define RUSFLX_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RUSFLX_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/rusflx_pkg.sv */
// Shared constants, types and Q16.16 arithmetic helpers for the Rusanov flux unit.
`default_nettype none
package rusflx_pkg;
	localparam int unsigned QONE        = 65536;
	localparam int unsigned DIV_STAGES  = 32;
	localparam int unsigned SQRT_STAGES = 24;
	localparam int unsigned LAT         = 64;
	localparam int unsigned DLA_DEPTH   = 28;
	localparam int unsigned DLB_DEPTH   = 23;

	localparam logic [1:0]  REG_GAMMA = 2'd0;
	localparam logic [1:0]  REG_SCALE = 2'd1;
	localparam logic [18:0] GAMMA_RST = 19'd91750;
	localparam logic [18:0] SCALE_RST = 19'd65536;

	typedef struct packed {
		logic [31:0] v;
		logic        ov;
	} qres_t;

	function automatic qres_t qsat64(input logic [63:0] x);
		qres_t r;
		r.v  = x[31:0];
		r.ov = 1'b0;
		if (!x[63] && (|x[62:31])) begin
			r.v  = 32'h7fff_ffff;
			r.ov = 1'b1;
		end else if (x[63] && !(&x[62:31])) begin
			r.v  = 32'h8000_0000;
			r.ov = 1'b1;
		end
		return r;
	endfunction

	function automatic qres_t qsat33(input logic [32:0] s);
		qres_t r;
		r.v  = s[31:0];
		r.ov = 1'b0;
		if (s[32] != s[31]) begin
			r.v  = s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
			r.ov = 1'b1;
		end
		return r;
	endfunction

	// product scaled by 2^-16, round half away from zero, saturated
	function automatic qres_t qmul(input logic [31:0] a, input logic [31:0] b);
		logic signed [31:0] sa;
		logic signed [31:0] sb;
		logic signed [63:0] p;
		logic [63:0] mag;
		logic [63:0] m;
		sa  = a;
		sb  = b;
		p   = sa * sb;
		mag = p[63] ? (~p + 64'd1) : p;
		m   = (mag + 64'd32768) >> 16;
		return qsat64(p[63] ? (~m + 64'd1) : m);
	endfunction

	function automatic qres_t qadd(input logic [31:0] a, input logic [31:0] b);
		return qsat33({a[31], a} + {b[31], b});
	endfunction

	function automatic qres_t qsub(input logic [31:0] a, input logic [31:0] b);
		return qsat33({a[31], a} - {b[31], b});
	endfunction

	function automatic logic [31:0] qhalf33(input logic [32:0] x);
		logic [32:0] mag;
		logic [32:0] m;
		logic [32:0] r;
		mag = x[32] ? (~x + 33'd1) : x;
		m   = (mag + 33'd1) >> 1;
		r   = x[32] ? (~m + 33'd1) : m;
		return r[31:0];
	endfunction

	function automatic qres_t qabs(input logic [31:0] a);
		qres_t r;
		r.ov = 1'b0;
		r.v  = a[31] ? (~a + 32'd1) : a;
		if (a == 32'h8000_0000) begin
			r.v  = 32'h7fff_ffff;
			r.ov = 1'b1;
		end
		return r;
	endfunction
endpackage
`default_nettype wire

/* rtl/rusflx_if.sv */
// Request channels of the Rusanov flux unit: faces in, fluxes out, register writes.
`default_nettype none
interface rusflx_face_if;
	logic               valid;
	logic               ready;
	logic [30:0]        left_density;
	logic signed [31:0] left_velocity_x;
	logic signed [31:0] left_velocity_y;
	logic [30:0]        left_pressure;
	logic [30:0]        right_density;
	logic signed [31:0] right_velocity_x;
	logic signed [31:0] right_velocity_y;
	logic [30:0]        right_pressure;
	logic signed [17:0] normal_x;
	logic signed [17:0] normal_y;
	modport source(output valid, left_density, left_velocity_x, left_velocity_y,
		left_pressure, right_density, right_velocity_x, right_velocity_y,
		right_pressure, normal_x, normal_y, input ready);
	modport sink(input valid, left_density, left_velocity_x, left_velocity_y,
		left_pressure, right_density, right_velocity_x, right_velocity_y,
		right_pressure, normal_x, normal_y, output ready);
endinterface

interface rusflx_flux_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] mass_flux;
	logic signed [31:0] momentum_flux_x;
	logic signed [31:0] momentum_flux_y;
	logic signed [31:0] energy_flux;
	logic               overflow;
	modport source(output valid, mass_flux, momentum_flux_x, momentum_flux_y,
		energy_flux, overflow, input ready);
	modport sink(input valid, mass_flux, momentum_flux_x, momentum_flux_y,
		energy_flux, overflow, output ready);
endinterface

interface rusflx_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [18:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/rusflx_div.sv */
// Pipelined restoring divider: round(num * 2^16 / den), saturated, one quotient bit per stage.
`default_nettype none
module rusflx_div import rusflx_pkg::*; (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [30:0] num,
	input  wire logic [31:0] den,
	output logic      [30:0] quo,
	output logic             ovf
);
	logic [31:0] rem_s [DIV_STAGES];
	logic [30:0] lo_s  [DIV_STAGES];
	logic [30:0] q_s   [DIV_STAGES];
	logic [31:0] den_s [DIV_STAGES];
	logic        ov_s  [DIV_STAGES];

	logic [47:0] n0;
	logic [31:0] rem_n [DIV_STAGES];
	logic [30:0] q_n   [DIV_STAGES];

	assign n0 = {1'b0, num, 16'b0} + {17'b0, den[31:1]};

	always_comb begin
		logic [32:0] t;
		rem_n[0] = {15'b0, n0[47:31]};
		q_n[0]   = '0;
		for (int k = 1; k < DIV_STAGES; k++) begin
			t = {rem_s[k-1], lo_s[k-1][30]};
			if (t >= {1'b0, den_s[k-1]}) begin
				rem_n[k] = 32'(t - {1'b0, den_s[k-1]});
				q_n[k]   = {q_s[k-1][29:0], 1'b1};
			end else begin
				rem_n[k] = t[31:0];
				q_n[k]   = {q_s[k-1][29:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= rem_n[0];
			q_s[0]   <= q_n[0];
			lo_s[0]  <= n0[30:0];
			den_s[0] <= den;
			ov_s[0]  <= {15'b0, n0[47:31]} >= den;
			for (int k = 1; k < DIV_STAGES; k++) begin
				rem_s[k] <= rem_n[k];
				q_s[k]   <= q_n[k];
				lo_s[k]  <= {lo_s[k-1][29:0], 1'b0};
				den_s[k] <= den_s[k-1];
				ov_s[k]  <= ov_s[k-1];
			end
		end
	end

	assign quo = ov_s[DIV_STAGES-1] ? '1 : q_s[DIV_STAGES-1];
	assign ovf = ov_s[DIV_STAGES-1];
endmodule
`default_nettype wire

/* rtl/rusflx_sqrt.sv */
// Pipelined digit-by-digit square root: floor(sqrt(x * 2^16)), one root bit per stage.
`default_nettype none
module rusflx_sqrt import rusflx_pkg::*; (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [30:0] x,
	input  wire logic        flg_in,
	output logic      [23:0] root,
	output logic             flg_out
);
	logic [23:0] rt_s [SQRT_STAGES];
	logic [25:0] rm_s [SQRT_STAGES];
	logic [47:0] vv_s [SQRT_STAGES];
	logic        fl_s [SQRT_STAGES];

	logic [23:0] rt_n [SQRT_STAGES];
	logic [25:0] rm_n [SQRT_STAGES];
	logic [47:0] vv_n [SQRT_STAGES];

	always_comb begin
		logic [23:0] rt_p;
		logic [25:0] rm_p;
		logic [47:0] vv_p;
		logic [27:0] t;
		logic [27:0] trial;
		for (int k = 0; k < SQRT_STAGES; k++) begin
			if (k == 0) begin
				rt_p = '0;
				rm_p = '0;
				vv_p = {1'b0, x, 16'b0};
			end else begin
				rt_p = rt_s[k-1];
				rm_p = rm_s[k-1];
				vv_p = vv_s[k-1];
			end
			t     = {rm_p, vv_p[47:46]};
			trial = {2'b0, rt_p, 2'b01};
			if (t >= trial) begin
				rm_n[k] = 26'(t - trial);
				rt_n[k] = {rt_p[22:0], 1'b1};
			end else begin
				rm_n[k] = t[25:0];
				rt_n[k] = {rt_p[22:0], 1'b0};
			end
			vv_n[k] = {vv_p[45:0], 2'b00};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < SQRT_STAGES; k++) begin
				rt_s[k] <= rt_n[k];
				rm_s[k] <= rm_n[k];
				vv_s[k] <= vv_n[k];
			end
			fl_s[0] <= flg_in;
			for (int k = 1; k < SQRT_STAGES; k++)
				fl_s[k] <= fl_s[k-1];
		end
	end

	assign root    = rt_s[SQRT_STAGES-1];
	assign flg_out = fl_s[SQRT_STAGES-1];
endmodule
`default_nettype wire

/* rtl/rusanov_euler_flux_2d_unit.sv */
// Top level of the Rusanov (local Lax-Friedrichs) 2D Euler face flux unit.
`default_nettype none
`include "rusanov_euler_flux_2d_unit_macros.svh"
// One face enters per clock while the output is not stalled; a stall at the output
// freezes the whole pipeline, so nothing is dropped or repeated. The latency is
// set by the sound-speed path: a multiply, a 32-stage divider (gamma*p/rho) and a
// 24-stage square root; the p/(gamma-1) divider runs beside it. Write the registers
// only while no face is in flight.
module rusanov_euler_flux_2d_unit import rusflx_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	rusflx_face_if.sink   face,
	rusflx_flux_if.source flux,
	rusflx_cfg_if.sink    cfg
);
	typedef struct packed {
		logic [31:0] rho, ru, rv, m, f1, f2, hrq, avn, vn, p;
	} sda_t;
	typedef struct packed {
		sda_t [1:0] sd;
		logic       ov;
	} bda_t;
	typedef struct packed {
		logic [31:0] rho, ru, rv, rhoe, m, f1, f2, avn, vn, x;
	} sdb_t;
	typedef struct packed {
		sdb_t [1:0] sd;
		logic       ov;
	} bdb_t;
	typedef struct packed {
		logic [31:0] rho, ru, rv, rhoe, m, f1, f2, f3, avn;
	} sdc_t;
	typedef struct packed {
		sdc_t [1:0] sd;
		logic       ov;
	} bdc_t;

	logic [18:0]    gam_q;
	logic [18:0]    scl_q;
	logic [LAT-1:0] vld_q;
	logic           adv;
	logic [31:0]    g1;

	assign adv       = !vld_q[LAT-1] || flux.ready;
	assign face.ready = adv;
	assign cfg.ready  = 1'b1;
	assign g1 = (gam_q > 19'(QONE)) ? (32'(gam_q) - 32'(QONE)) : 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gam_q <= GAMMA_RST;
			scl_q <= SCALE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_GAMMA: gam_q <= cfg.data;
				REG_SCALE: scl_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], face.valid};
		end
	end

	// stage 1: input capture
	logic [30:0] rho_s1 [2];
	logic [31:0] u_s1   [2];
	logic [31:0] v_s1   [2];
	logic [30:0] p_s1   [2];
	logic [17:0] nx_s1, ny_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			rho_s1[0] <= face.left_density;
			u_s1[0]   <= face.left_velocity_x;
			v_s1[0]   <= face.left_velocity_y;
			p_s1[0]   <= face.left_pressure;
			rho_s1[1] <= face.right_density;
			u_s1[1]   <= face.right_velocity_x;
			v_s1[1]   <= face.right_velocity_y;
			p_s1[1]   <= face.right_pressure;
			nx_s1     <= face.normal_x;
			ny_s1     <= face.normal_y;
		end
	end

	// stage 2: first products
	logic [31:0] nx32, ny32;
	qres_t c2_un [2], c2_vny [2], c2_uu [2], c2_vv [2];
	qres_t c2_ru [2], c2_rv [2], c2_pnx [2], c2_pny [2], c2_gp [2];
	logic  ov2;

	assign nx32 = {{14{nx_s1[17]}}, nx_s1};
	assign ny32 = {{14{ny_s1[17]}}, ny_s1};

	always_comb begin
		ov2 = 1'b0;
		for (int i = 0; i < 2; i++) begin
			c2_un[i]  = qmul(u_s1[i], nx32);
			c2_vny[i] = qmul(v_s1[i], ny32);
			c2_uu[i]  = qmul(u_s1[i], u_s1[i]);
			c2_vv[i]  = qmul(v_s1[i], v_s1[i]);
			c2_ru[i]  = qmul({1'b0, rho_s1[i]}, u_s1[i]);
			c2_rv[i]  = qmul({1'b0, rho_s1[i]}, v_s1[i]);
			c2_pnx[i] = qmul({1'b0, p_s1[i]}, nx32);
			c2_pny[i] = qmul({1'b0, p_s1[i]}, ny32);
			c2_gp[i]  = qmul({13'b0, gam_q}, {1'b0, p_s1[i]});
			ov2 = ov2 | c2_un[i].ov | c2_vny[i].ov | c2_uu[i].ov | c2_vv[i].ov
				| c2_ru[i].ov | c2_rv[i].ov | c2_pnx[i].ov | c2_pny[i].ov | c2_gp[i].ov;
		end
	end

	logic [31:0] un_s2 [2], vny_s2 [2], uu_s2 [2], vv_s2 [2];
	logic [31:0] ru_s2 [2], rv_s2 [2], pnx_s2 [2], pny_s2 [2], gp_s2 [2];
	logic [31:0] rho_s2 [2], u_s2 [2], v_s2 [2], p_s2 [2], rhof_s2 [2];
	logic        ov_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 2; i++) begin
				un_s2[i]   <= c2_un[i].v;
				vny_s2[i]  <= c2_vny[i].v;
				uu_s2[i]   <= c2_uu[i].v;
				vv_s2[i]   <= c2_vv[i].v;
				ru_s2[i]   <= c2_ru[i].v;
				rv_s2[i]   <= c2_rv[i].v;
				pnx_s2[i]  <= c2_pnx[i].v;
				pny_s2[i]  <= c2_pny[i].v;
				gp_s2[i]   <= c2_gp[i].v;
				rho_s2[i]  <= {1'b0, rho_s1[i]};
				u_s2[i]    <= u_s1[i];
				v_s2[i]    <= v_s1[i];
				p_s2[i]    <= {1'b0, p_s1[i]};
				rhof_s2[i] <= (rho_s1[i] == '0) ? 32'd1 : {1'b0, rho_s1[i]};
			end
			ov_s2 <= ov2;
		end
	end

	// pipelined divider and square-root units: p/(gamma-1), and sqrt(gamma*p/rho)
	wire [30:0] pdiv   [2];
	wire        pdv_ov [2];
	wire [30:0] cdiv   [2];
	wire        cdv_ov [2];
	wire [23:0] snd    [2];
	wire        snd_ov [2];

	for (genvar g = 0; g < 2; g++) begin : g_side
		rusflx_div u_pdiv (
			.clk (clk),
			.en  (adv),
			.num (p_s1[g]),
			.den (g1),
			.quo (pdiv[g]),
			.ovf (pdv_ov[g])
		);
		rusflx_div u_cdiv (
			.clk (clk),
			.en  (adv),
			.num (gp_s2[g][30:0]),
			.den (rhof_s2[g]),
			.quo (cdiv[g]),
			.ovf (cdv_ov[g])
		);
		rusflx_sqrt u_sqrt (
			.clk     (clk),
			.en      (adv),
			.x       (cdiv[g]),
			.flg_in  (cdv_ov[g]),
			.root    (snd[g]),
			.flg_out (snd_ov[g])
		);
	end

	// stage 3: normal velocity, speed squared
	qres_t c3_vn [2], c3_q2 [2];
	logic  ov3;

	always_comb begin
		ov3 = ov_s2;
		for (int i = 0; i < 2; i++) begin
			c3_vn[i] = qadd(un_s2[i], vny_s2[i]);
			c3_q2[i] = qadd(uu_s2[i], vv_s2[i]);
			ov3 = ov3 | c3_vn[i].ov | c3_q2[i].ov;
		end
	end

	logic [31:0] vn_s3 [2], q2_s3 [2], rho_s3 [2], u_s3 [2], v_s3 [2], p_s3 [2];
	logic [31:0] ru_s3 [2], rv_s3 [2], pnx_s3 [2], pny_s3 [2];
	logic        ov_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 2; i++) begin
				vn_s3[i]  <= c3_vn[i].v;
				q2_s3[i]  <= c3_q2[i].v;
				rho_s3[i] <= rho_s2[i];
				u_s3[i]   <= u_s2[i];
				v_s3[i]   <= v_s2[i];
				p_s3[i]   <= p_s2[i];
				ru_s3[i]  <= ru_s2[i];
				rv_s3[i]  <= rv_s2[i];
				pnx_s3[i] <= pnx_s2[i];
				pny_s3[i] <= pny_s2[i];
			end
			ov_s3 <= ov3;
		end
	end

	// stage 4: rho*q2, mass flux
	qres_t c4_rq [2], c4_m [2];
	logic  ov4;

	always_comb begin
		ov4 = ov_s3;
		for (int i = 0; i < 2; i++) begin
			c4_rq[i] = qmul(rho_s3[i], q2_s3[i]);
			c4_m[i]  = qmul(rho_s3[i], vn_s3[i]);
			ov4 = ov4 | c4_rq[i].ov | c4_m[i].ov;
		end
	end

	logic [31:0] rq_s4 [2], m_s4 [2], vn_s4 [2], u_s4 [2], v_s4 [2], p_s4 [2];
	logic [31:0] rho_s4 [2], ru_s4 [2], rv_s4 [2], pnx_s4 [2], pny_s4 [2];
	logic        ov_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 2; i++) begin
				rq_s4[i]  <= c4_rq[i].v;
				m_s4[i]   <= c4_m[i].v;
				vn_s4[i]  <= vn_s3[i];
				u_s4[i]   <= u_s3[i];
				v_s4[i]   <= v_s3[i];
				p_s4[i]   <= p_s3[i];
				rho_s4[i] <= rho_s3[i];
				ru_s4[i]  <= ru_s3[i];
				rv_s4[i]  <= rv_s3[i];
				pnx_s4[i] <= pnx_s3[i];
				pny_s4[i] <= pny_s3[i];
			end
			ov_s4 <= ov4;
		end
	end

	// stage 5: kinetic energy half, momentum convection, |Vn|
	qres_t c5_mu [2], c5_mv [2], c5_avn [2];
	logic  ov5;

	always_comb begin
		ov5 = ov_s4;
		for (int i = 0; i < 2; i++) begin
			c5_mu[i]  = qmul(m_s4[i], u_s4[i]);
			c5_mv[i]  = qmul(m_s4[i], v_s4[i]);
			c5_avn[i] = qabs(vn_s4[i]);
			ov5 = ov5 | c5_mu[i].ov | c5_mv[i].ov | c5_avn[i].ov;
		end
	end

	logic [31:0] hrq_s5 [2], mu_s5 [2], mv_s5 [2], avn_s5 [2], vn_s5 [2], p_s5 [2];
	logic [31:0] rho_s5 [2], ru_s5 [2], rv_s5 [2], pnx_s5 [2], pny_s5 [2], m_s5 [2];
	logic        ov_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 2; i++) begin
				hrq_s5[i] <= qhalf33({rq_s4[i][31], rq_s4[i]});
				mu_s5[i]  <= c5_mu[i].v;
				mv_s5[i]  <= c5_mv[i].v;
				avn_s5[i] <= c5_avn[i].v;
				vn_s5[i]  <= vn_s4[i];
				p_s5[i]   <= p_s4[i];
				rho_s5[i] <= rho_s4[i];
				ru_s5[i]  <= ru_s4[i];
				rv_s5[i]  <= rv_s4[i];
				pnx_s5[i] <= pnx_s4[i];
				pny_s5[i] <= pny_s4[i];
				m_s5[i]   <= m_s4[i];
			end
			ov_s5 <= ov5;
		end
	end

	// stage 6 and the wait for p/(gamma-1)
	bda_t b6;
	bda_t dla_q [DLA_DEPTH];

	always_comb begin
		qres_t f1;
		qres_t f2;
		b6.ov = ov_s5;
		for (int i = 0; i < 2; i++) begin
			f1 = qadd(mu_s5[i], pnx_s5[i]);
			f2 = qadd(mv_s5[i], pny_s5[i]);
			b6.sd[i].rho = rho_s5[i];
			b6.sd[i].ru  = ru_s5[i];
			b6.sd[i].rv  = rv_s5[i];
			b6.sd[i].m   = m_s5[i];
			b6.sd[i].f1  = f1.v;
			b6.sd[i].f2  = f2.v;
			b6.sd[i].hrq = hrq_s5[i];
			b6.sd[i].avn = avn_s5[i];
			b6.sd[i].vn  = vn_s5[i];
			b6.sd[i].p   = p_s5[i];
			b6.ov = b6.ov | f1.ov | f2.ov;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dla_q[0] <= b6;
			for (int k = 1; k < DLA_DEPTH; k++)
				dla_q[k] <= dla_q[k-1];
		end
	end

	// stage 34: total energy
	bdb_t b34, b34_s34, b35, b35_s35;
	bda_t da;

	assign da = dla_q[DLA_DEPTH-1];

	always_comb begin
		qres_t e;
		b34.ov = da.ov;
		for (int i = 0; i < 2; i++) begin
			e = qadd({1'b0, pdiv[i]}, da.sd[i].hrq);
			b34.sd[i].rho  = da.sd[i].rho;
			b34.sd[i].ru   = da.sd[i].ru;
			b34.sd[i].rv   = da.sd[i].rv;
			b34.sd[i].rhoe = e.v;
			b34.sd[i].m    = da.sd[i].m;
			b34.sd[i].f1   = da.sd[i].f1;
			b34.sd[i].f2   = da.sd[i].f2;
			b34.sd[i].avn  = da.sd[i].avn;
			b34.sd[i].vn   = da.sd[i].vn;
			b34.sd[i].x    = da.sd[i].p;
			b34.ov = b34.ov | e.ov | pdv_ov[i];
		end
	end

	// stage 35: rhoE + p
	always_comb begin
		qres_t e;
		b35 = b34_s34;
		for (int i = 0; i < 2; i++) begin
			e = qadd(b34_s34.sd[i].rhoe, b34_s34.sd[i].x);
			b35.sd[i].x = e.v;
			b35.ov = b35.ov | e.ov;
		end
	end

	// stage 36: energy flux, then the wait for the sound speed
	bdc_t b36;
	bdc_t dlb_q [DLB_DEPTH];

	always_comb begin
		qres_t e;
		b36.ov = b35_s35.ov;
		for (int i = 0; i < 2; i++) begin
			e = qmul(b35_s35.sd[i].vn, b35_s35.sd[i].x);
			b36.sd[i].rho  = b35_s35.sd[i].rho;
			b36.sd[i].ru   = b35_s35.sd[i].ru;
			b36.sd[i].rv   = b35_s35.sd[i].rv;
			b36.sd[i].rhoe = b35_s35.sd[i].rhoe;
			b36.sd[i].m    = b35_s35.sd[i].m;
			b36.sd[i].f1   = b35_s35.sd[i].f1;
			b36.sd[i].f2   = b35_s35.sd[i].f2;
			b36.sd[i].f3   = e.v;
			b36.sd[i].avn  = b35_s35.sd[i].avn;
			b36.ov = b36.ov | e.ov;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b34_s34  <= b34;
			b35_s35  <= b35;
			dlb_q[0] <= b36;
			for (int k = 1; k < DLB_DEPTH; k++)
				dlb_q[k] <= dlb_q[k-1];
		end
	end

	// stage 59: wave speed |Vn| + a, held in the avn slot
	bdc_t b59, b59_s59;
	bdc_t db;

	assign db = dlb_q[DLB_DEPTH-1];

	always_comb begin
		qres_t w;
		b59 = db;
		for (int i = 0; i < 2; i++) begin
			w = qadd(db.sd[i].avn, {8'b0, snd[i]});
			b59.sd[i].avn = w.v;
			b59.ov = b59.ov | w.ov | snd_ov[i];
		end
	end

	// stage 60: max wave speed, conservative jumps, flux sums
	logic [31:0] ul [4], ur [4], fl [4], fr [4];
	qres_t       c60_du [4];
	logic        ov60;

	always_comb begin
		ul[0] = b59_s59.sd[0].rho;  ur[0] = b59_s59.sd[1].rho;
		ul[1] = b59_s59.sd[0].ru;   ur[1] = b59_s59.sd[1].ru;
		ul[2] = b59_s59.sd[0].rv;   ur[2] = b59_s59.sd[1].rv;
		ul[3] = b59_s59.sd[0].rhoe; ur[3] = b59_s59.sd[1].rhoe;
		fl[0] = b59_s59.sd[0].m;    fr[0] = b59_s59.sd[1].m;
		fl[1] = b59_s59.sd[0].f1;   fr[1] = b59_s59.sd[1].f1;
		fl[2] = b59_s59.sd[0].f2;   fr[2] = b59_s59.sd[1].f2;
		fl[3] = b59_s59.sd[0].f3;   fr[3] = b59_s59.sd[1].f3;
		ov60 = b59_s59.ov;
		for (int k = 0; k < 4; k++) begin
			c60_du[k] = qsub(ur[k], ul[k]);
			ov60 = ov60 | c60_du[k].ov;
		end
	end

	logic [31:0] lam_s60;
	logic [31:0] du_s60 [4];
	logic [32:0] sf_s60 [4];
	logic        ov_s60;

	// stage 61..64: dissipation and final flux
	qres_t       c61_sl;
	logic [31:0] sl_s61;
	logic [31:0] mean_s61 [4], du_s61 [4];
	logic        ov_s61;
	logic [31:0] h_s62;
	logic [31:0] mean_s62 [4], du_s62 [4];
	logic        ov_s62;
	qres_t       c63_ds [4];
	logic        ov63;
	logic [31:0] ds_s63 [4], mean_s63 [4];
	logic        ov_s63;
	qres_t       c64_r [4];
	logic        ov64;
	logic [31:0] res_s64 [4];
	logic        ov_s64;

	assign c61_sl = qmul({13'b0, scl_q}, lam_s60);

	always_comb begin
		ov63 = ov_s62;
		ov64 = ov_s63;
		for (int k = 0; k < 4; k++) begin
			c63_ds[k] = qmul(h_s62, du_s62[k]);
			c64_r[k]  = qsub(mean_s63[k], ds_s63[k]);
			ov63 = ov63 | c63_ds[k].ov;
			ov64 = ov64 | c64_r[k].ov;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b59_s59 <= b59;
			lam_s60 <= ($signed(b59_s59.sd[0].avn) > $signed(b59_s59.sd[1].avn))
				? b59_s59.sd[0].avn : b59_s59.sd[1].avn;
			ov_s60  <= ov60;
			sl_s61  <= c61_sl.v;
			ov_s61  <= ov_s60 | c61_sl.ov;
			h_s62   <= qhalf33({sl_s61[31], sl_s61});
			ov_s62  <= ov_s61;
			ov_s63  <= ov63;
			ov_s64  <= ov64;
			for (int k = 0; k < 4; k++) begin
				du_s60[k]   <= c60_du[k].v;
				sf_s60[k]   <= {fl[k][31], fl[k]} + {fr[k][31], fr[k]};
				mean_s61[k] <= qhalf33(sf_s60[k]);
				du_s61[k]   <= du_s60[k];
				mean_s62[k] <= mean_s61[k];
				du_s62[k]   <= du_s61[k];
				ds_s63[k]   <= c63_ds[k].v;
				mean_s63[k] <= mean_s62[k];
				res_s64[k]  <= c64_r[k].v;
			end
		end
	end

	assign flux.valid           = vld_q[LAT-1];
	assign flux.mass_flux       = res_s64[0];
	assign flux.momentum_flux_x = res_s64[1];
	assign flux.momentum_flux_y = res_s64[2];
	assign flux.energy_flux     = res_s64[3];
	assign flux.overflow        = ov_s64;

	`RUSFLX_ASSERT_IMP(a_stall_blocks_in, clk, arst_n, flux.valid && !flux.ready, !face.ready)
	`RUSFLX_ASSERT_NXT(a_request_enters, clk, arst_n, face.valid && face.ready, vld_q[0])
	`RUSFLX_ASSERT_NXT(a_out_drains, clk, arst_n, flux.valid && flux.ready && !vld_q[LAT-2], !flux.valid)
endmodule
`default_nettype wire
